// ===== rtl/scpt_pkg.sv =====
// Shared types and constants for the serial command periodic trigger.
package scpt_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result kinds
  localparam logic [1:0] KIND_CLIMATE = 2'd0;
  localparam logic [1:0] KIND_SOIL    = 2'd1;
  localparam logic [1:0] KIND_REFRESH = 2'd2;
  localparam logic [1:0] KIND_STATUS  = 2'd3;

  // Command status codes
  localparam logic [2:0] ST_CLIMATE_SET = 3'd0;
  localparam logic [2:0] ST_SOIL_SET    = 3'd1;
  localparam logic [2:0] ST_REFRESH_SET = 3'd2;
  localparam logic [2:0] ST_DISP_SET    = 3'd3;
  localparam logic [2:0] ST_DISP_BAD    = 3'd4;
  localparam logic [2:0] ST_UNKNOWN     = 3'd5;
  localparam logic [2:0] ST_MALFORMED   = 3'd6;
  localparam logic [2:0] ST_NONE        = 3'd0;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_UP_L  = 8'h4C;
  localparam logic [7:0] CH_UP_S  = 8'h53;
  localparam logic [7:0] CH_UP_T  = 8'h54;
  localparam logic [7:0] CH_LO_D  = 8'h64;
  localparam logic [7:0] CH_LO_L  = 8'h6C;
  localparam logic [7:0] CH_LO_S  = 8'h73;
  localparam logic [7:0] CH_LO_T  = 8'h74;

  localparam logic [31:0] CLIMATE_PERIOD_RST = 32'd500;
  localparam logic [31:0] SOIL_PERIOD_RST    = 32'd1000;
  localparam logic [31:0] REFRESH_PERIOD_RST = 32'd2000;
  localparam logic [31:0] MAG_LIMIT          = 32'h8000_0000;
  localparam logic [31:0] POS_MAX            = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    PH_LETTER,
    PH_COLON,
    PH_BLANKS,
    PH_SIGNED,
    PH_DIGITS,
    PH_STOPPED
  } phase_t;

  // Work handed from the parser to the trigger engine
  typedef struct packed {
    logic        is_tick;
    logic [2:0]  status;
    logic [31:0] value;
  } job_t;

endpackage

// ===== rtl/scpt_if.sv =====
// Handshake channel interfaces for the input and result streams.
interface scpt_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface scpt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         status;
  logic signed [31:0] applied_value;
  logic [1:0]         display_mode;
  logic               last;

  modport source (output valid, output kind, output status, output applied_value,
                  output display_mode, output last, input ready);
  modport sink   (input valid, input kind, input status, input applied_value,
                  input display_mode, input last, output ready);
endinterface

// ===== rtl/serial_command_periodic_trigger.sv =====
// Serial command parser with three periodic millisecond triggers. A byte or a tick is
// accepted in every cycle while the four-entry job queue has room; bytes are parsed as
// they arrive, and a non-empty line end or a tick puts one job in the queue. The back
// end gives its results one at a time, so a tick that fires all three triggers gives
// three results, a command one or two (a good D command gives its status and then a
// refresh), and a tick that fires nothing gives none; the result register lets the next
// job start while the last result still waits to be taken. Periods reset to 500, 1000
// and 2000 ticks, counters and display mode to zero. Lines keep LINE_CAPACITY-1 bytes.
module serial_command_periodic_trigger #(
  parameter int LINE_CAPACITY = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  scpt_in_if.sink    in_ch,
  scpt_out_if.source out_ch
);

  logic           q_full;
  logic           q_empty;
  logic           push_vld;
  logic           pop;
  scpt_pkg::job_t push_job;
  scpt_pkg::job_t head_job;

  scpt_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push_vld (push_vld),
    .push_job (push_job)
  );

  scpt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_vld),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  scpt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head_job (head_job),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/scpt_front.sv =====
// Front end: accepts bytes and ticks, parses command lines, emits jobs.
module scpt_front #(
  parameter int LINE_CAPACITY = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  scpt_in_if.sink       in_ch,
  input  logic          q_full,
  output logic          push_vld,
  output scpt_pkg::job_t push_job
);

  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

  logic [LEN_W-1:0]  len_r, len_nxt;
  scpt_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]        letter_r, letter_nxt;
  logic              neg_r, neg_nxt;
  logic [31:0]       mag_r, mag_nxt;
  logic              digit_r, digit_nxt;
  logic              ended_r, ended_nxt;

  logic        accept;
  logic        is_eol;
  logic        is_digit;
  logic [35:0] mag_acc;
  logic [31:0] value;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_eol      = (in_ch.rx_byte == scpt_pkg::CH_LF) || (in_ch.rx_byte == scpt_pkg::CH_CR);
  assign is_digit    = (in_ch.rx_byte >= scpt_pkg::CH_ZERO) &&
                       (in_ch.rx_byte <= scpt_pkg::CH_NINE);

  // mag * 10 + digit, as shift-and-add
  assign mag_acc = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} +
                   {32'd0, in_ch.rx_byte[3:0]};

  // Parser next state
  always_comb begin
    len_nxt    = len_r;
    phase_nxt  = phase_r;
    letter_nxt = letter_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    digit_nxt  = digit_r;
    ended_nxt  = ended_r;
    if (accept && !in_ch.mode) begin
      if (is_eol) begin
        if (len_r != '0) begin
          len_nxt    = '0;
          phase_nxt  = scpt_pkg::PH_LETTER;
          letter_nxt = '0;
          neg_nxt    = 1'b0;
          mag_nxt    = '0;
          digit_nxt  = 1'b0;
          ended_nxt  = 1'b0;
        end
      end else if (len_r < LEN_MAX) begin
        len_nxt = len_r + 1'b1;
        if (!ended_r) begin
          if (in_ch.rx_byte == scpt_pkg::CH_NUL) begin
            ended_nxt = 1'b1;
          end else begin
            case (phase_r)
              scpt_pkg::PH_LETTER: begin
                letter_nxt = in_ch.rx_byte;
                phase_nxt  = scpt_pkg::PH_COLON;
              end
              scpt_pkg::PH_COLON: begin
                phase_nxt = (in_ch.rx_byte == scpt_pkg::CH_COLON) ?
                            scpt_pkg::PH_BLANKS : scpt_pkg::PH_STOPPED;
              end
              scpt_pkg::PH_BLANKS, scpt_pkg::PH_SIGNED, scpt_pkg::PH_DIGITS: begin
                if (phase_r == scpt_pkg::PH_BLANKS && (in_ch.rx_byte inside
                    {scpt_pkg::CH_SP, scpt_pkg::CH_TAB, scpt_pkg::CH_VT, scpt_pkg::CH_FF})) begin
                  // skip blank
                end else if (phase_r == scpt_pkg::PH_BLANKS && (in_ch.rx_byte inside
                    {scpt_pkg::CH_PLUS, scpt_pkg::CH_MINUS})) begin
                  neg_nxt   = (in_ch.rx_byte == scpt_pkg::CH_MINUS);
                  phase_nxt = scpt_pkg::PH_SIGNED;
                end else if (is_digit) begin
                  mag_nxt   = (mag_acc > {4'd0, scpt_pkg::MAG_LIMIT}) ?
                              scpt_pkg::MAG_LIMIT : mag_acc[31:0];
                  digit_nxt = 1'b1;
                  phase_nxt = scpt_pkg::PH_DIGITS;
                end else begin
                  phase_nxt = scpt_pkg::PH_STOPPED;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  // Job outputs
  always_comb begin
    push_vld = accept && (in_ch.mode || (is_eol && len_r != '0));
    value    = neg_r ? (32'd0 - mag_r) : (mag_r[31] ? scpt_pkg::POS_MAX : mag_r);
    push_job.is_tick = in_ch.mode;
    push_job.value   = value;
    if (!digit_r) begin
      push_job.status = scpt_pkg::ST_MALFORMED;
      push_job.value  = '0;
    end else if (letter_r inside {scpt_pkg::CH_UP_T, scpt_pkg::CH_LO_T}) begin
      push_job.status = scpt_pkg::ST_CLIMATE_SET;
    end else if (letter_r inside {scpt_pkg::CH_UP_S, scpt_pkg::CH_LO_S}) begin
      push_job.status = scpt_pkg::ST_SOIL_SET;
    end else if (letter_r inside {scpt_pkg::CH_UP_L, scpt_pkg::CH_LO_L}) begin
      push_job.status = scpt_pkg::ST_REFRESH_SET;
    end else if (letter_r inside {scpt_pkg::CH_UP_D, scpt_pkg::CH_LO_D}) begin
      push_job.status = (value[31:2] == '0) ? scpt_pkg::ST_DISP_SET : scpt_pkg::ST_DISP_BAD;
    end else begin
      push_job.status = scpt_pkg::ST_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      phase_r  <= scpt_pkg::PH_LETTER;
      letter_r <= '0;
      neg_r    <= 1'b0;
      mag_r    <= '0;
      digit_r  <= 1'b0;
      ended_r  <= 1'b0;
    end else begin
      len_r    <= len_nxt;
      phase_r  <= phase_nxt;
      letter_r <= letter_nxt;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
      digit_r  <= digit_nxt;
      ended_r  <= ended_nxt;
    end
  end

endmodule

// ===== rtl/scpt_fifo.sv =====
// Short job queue between the parser and the trigger engine.
module scpt_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scpt_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output scpt_pkg::job_t head_job
);

  scpt_pkg::job_t                   slot_r [scpt_pkg::QUEUE_DEPTH];
  logic [scpt_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [scpt_pkg::QCNT_W-1:0]      cnt_r;

  assign full     = (cnt_r == scpt_pkg::QCNT_W'(scpt_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + scpt_pkg::QCNT_W'(push) - scpt_pkg::QCNT_W'(pop);
    end
  end

endmodule

// ===== rtl/scpt_back.sv =====
// Back end: runs tick and command jobs, holds periods and counters, drives results.
module scpt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  scpt_pkg::job_t head_job,
  output logic           pop,
  scpt_out_if.source     out_ch
);

  // pending bits: 0 climate, 1 soil, 2 refresh, 3 command status
  logic [3:0]  pend_r, pend_nxt;
  logic [2:0]  pst_r, pst_nxt;
  logic [31:0] pval_r, pval_nxt;

  logic [31:0] clim_per_r, clim_per_nxt, soil_per_r, soil_per_nxt;
  logic [31:0] refr_per_r, refr_per_nxt;
  logic [31:0] clim_cnt_r, clim_cnt_nxt, soil_cnt_r, soil_cnt_nxt;
  logic [31:0] refr_cnt_r, refr_cnt_nxt;
  logic [1:0]  mode_r, mode_nxt;

  logic        ov_r, ov_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic [31:0] oval_r, oval_nxt;
  logic [1:0]  omode_r, omode_nxt;
  logic        olast_r, olast_nxt;

  logic        can_load;
  logic        load;
  logic [3:0]  sel;
  logic [3:0]  rem;
  logic [31:0] clim_inc, soil_inc, refr_inc;
  logic        fire_c, fire_s, fire_r;

  assign can_load = !ov_r || out_ch.ready;
  assign load     = can_load && (pend_r != '0);

  // Status goes first, then climate, soil, refresh
  always_comb begin
    if (pend_r[3]) begin
      sel = 4'b1000;
    end else if (pend_r[0]) begin
      sel = 4'b0001;
    end else if (pend_r[1]) begin
      sel = 4'b0010;
    end else begin
      sel = pend_r & 4'b0100;
    end
    rem = pend_r & ~sel;
  end

  assign pop = !q_empty && ((pend_r == '0) || (can_load && rem == '0));

  assign clim_inc = clim_cnt_r + 32'd1;
  assign soil_inc = soil_cnt_r + 32'd1;
  assign refr_inc = refr_cnt_r + 32'd1;
  assign fire_c   = clim_inc >= clim_per_r;
  assign fire_s   = soil_inc >= soil_per_r;
  assign fire_r   = refr_inc >= refr_per_r;

  // Job execution
  always_comb begin
    pend_nxt     = load ? rem : pend_r;
    pst_nxt      = pst_r;
    pval_nxt     = pval_r;
    clim_per_nxt = clim_per_r;
    soil_per_nxt = soil_per_r;
    refr_per_nxt = refr_per_r;
    clim_cnt_nxt = clim_cnt_r;
    soil_cnt_nxt = soil_cnt_r;
    refr_cnt_nxt = refr_cnt_r;
    mode_nxt     = mode_r;
    if (pop) begin
      if (head_job.is_tick) begin
        clim_cnt_nxt = fire_c ? '0 : clim_inc;
        soil_cnt_nxt = fire_s ? '0 : soil_inc;
        refr_cnt_nxt = fire_r ? '0 : refr_inc;
        pend_nxt     = {1'b0, fire_r, fire_s, fire_c};
      end else begin
        pst_nxt  = head_job.status;
        pval_nxt = head_job.value;
        pend_nxt = {1'b1, head_job.status == scpt_pkg::ST_DISP_SET, 2'b00};
        case (head_job.status)
          scpt_pkg::ST_CLIMATE_SET: clim_per_nxt = head_job.value;
          scpt_pkg::ST_SOIL_SET:    soil_per_nxt = head_job.value;
          scpt_pkg::ST_REFRESH_SET: refr_per_nxt = head_job.value;
          scpt_pkg::ST_DISP_SET:    mode_nxt     = head_job.value[1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result register
  always_comb begin
    ov_nxt    = ov_r && !out_ch.ready;
    okind_nxt = okind_r;
    ost_nxt   = ost_r;
    oval_nxt  = oval_r;
    omode_nxt = omode_r;
    olast_nxt = olast_r;
    if (load) begin
      ov_nxt    = 1'b1;
      omode_nxt = mode_r;
      olast_nxt = (rem == '0);
      ost_nxt   = sel[3] ? pst_r : scpt_pkg::ST_NONE;
      oval_nxt  = sel[3] ? pval_r : '0;
      if (sel[3]) begin
        okind_nxt = scpt_pkg::KIND_STATUS;
      end else if (sel[0]) begin
        okind_nxt = scpt_pkg::KIND_CLIMATE;
      end else if (sel[1]) begin
        okind_nxt = scpt_pkg::KIND_SOIL;
      end else begin
        okind_nxt = scpt_pkg::KIND_REFRESH;
      end
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.kind          = okind_r;
  assign out_ch.status        = ost_r;
  assign out_ch.applied_value = oval_r;
  assign out_ch.display_mode  = omode_r;
  assign out_ch.last          = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= '0;
      clim_per_r <= scpt_pkg::CLIMATE_PERIOD_RST;
      soil_per_r <= scpt_pkg::SOIL_PERIOD_RST;
      refr_per_r <= scpt_pkg::REFRESH_PERIOD_RST;
      clim_cnt_r <= '0;
      soil_cnt_r <= '0;
      refr_cnt_r <= '0;
      mode_r     <= '0;
      ov_r       <= 1'b0;
    end else begin
      pend_r     <= pend_nxt;
      clim_per_r <= clim_per_nxt;
      soil_per_r <= soil_per_nxt;
      refr_per_r <= refr_per_nxt;
      clim_cnt_r <= clim_cnt_nxt;
      soil_cnt_r <= soil_cnt_nxt;
      refr_cnt_r <= refr_cnt_nxt;
      mode_r     <= mode_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pst_r   <= pst_nxt;
    pval_r  <= pval_nxt;
    okind_r <= okind_nxt;
    ost_r   <= ost_nxt;
    oval_r  <= oval_nxt;
    omode_r <= omode_nxt;
    olast_r <= olast_nxt;
  end

endmodule

// ===== rtl/scpt_checker.sv =====
// Port-level checks on the result stream, bound to the top level.
module scpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [2:0]  out_status,
  input logic [31:0] out_value,
  input logic [1:0]  out_display_mode,
  input logic        out_last
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_status) &&
    $stable(out_value) && $stable(out_display_mode) && $stable(out_last))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Display set is always followed by its refresh
  a_disp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == scpt_pkg::KIND_STATUS && out_status == scpt_pkg::ST_DISP_SET
    |-> !out_last)
    else $error("display set marked last");

  a_trigger_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != scpt_pkg::KIND_STATUS |-> out_status == scpt_pkg::ST_NONE &&
    out_value == '0)
    else $error("trigger carries status or value");

  a_malformed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == scpt_pkg::KIND_STATUS && out_status == scpt_pkg::ST_MALFORMED
    |-> out_value == '0 && out_last)
    else $error("malformed line result wrong");

endmodule

bind serial_command_periodic_trigger scpt_checker u_scpt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_status       (out_ch.status),
  .out_value        (out_ch.applied_value),
  .out_display_mode (out_ch.display_mode),
  .out_last         (out_ch.last)
);

// ===== tb/sv/scpt_trigger_checker.sv =====
`timescale 1ns / 100ps
// Result checker: predicts command status and trigger results and compares every transaction.
module scpt_trigger_checker
  import scpt_pkg::*;
#(
  parameter int LINE_CAPACITY = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_mode,
  input  logic [7:0]         in_rx_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_kind,
  input  logic [2:0]         out_status,
  input  logic signed [31:0] out_applied_value,
  input  logic [1:0]         out_display_mode,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending_results
);

  localparam int IDX_CLIMATE = 0;
  localparam int IDX_SOIL    = 1;
  localparam int IDX_REFRESH = 2;
  localparam logic [2:0][1:0] TIMER_KIND = {KIND_REFRESH, KIND_SOIL, KIND_CLIMATE};
  localparam logic [2:0][2:0] PERIOD_SET = {ST_REFRESH_SET, ST_SOIL_SET, ST_CLIMATE_SET};
  localparam logic [31:0] TOP_DISPLAY_MODE = 32'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [31:0] value;
    logic [1:0]  disp;
    logic        last;
  } trig_result_t;

  trig_result_t expected_results[$];
  trig_result_t fresh[$];

  logic [31:0] period [3];
  logic [31:0] elapsed [3];
  logic [1:0]  disp_mode;
  int unsigned kept;
  phase_t      phase;
  logic [7:0]  letter;
  logic        negative;
  logic [31:0] magnitude;
  logic        digit_seen;
  logic        text_done;

  initial fail_count = 0;

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    fail_count++;
  endtask

  function automatic void drop_line();
    kept       = 0;
    phase      = PH_LETTER;
    letter     = '0;
    negative   = 1'b0;
    magnitude  = '0;
    digit_seen = 1'b0;
    text_done  = 1'b0;
  endfunction

  function automatic void emit(input logic [1:0] k, input logic [2:0] s, input logic [31:0] v);
    trig_result_t r;
    r.kind   = k;
    r.status = s;
    r.value  = v;
    r.disp   = disp_mode;
    r.last   = 1'b0;
    fresh.push_back(r);
  endfunction

  task automatic predict_results(input logic tick, input logic [7:0] c);
    logic [63:0] grown;
    logic [31:0] value;
    logic        blank;
    int          slot;
    fresh.delete();
    if (tick) begin
      for (int i = 0; i < 3; i++) elapsed[i] = elapsed[i] + 32'd1;
      // climate, soil, refresh order
      for (int i = 0; i < 3; i++) begin
        if (elapsed[i] >= period[i]) begin
          elapsed[i] = '0;
          emit(TIMER_KIND[i], ST_NONE, '0);
        end
      end
    end else if (c == CH_LF || c == CH_CR) begin
      if (kept != 0) begin
        if (!digit_seen) begin
          emit(KIND_STATUS, ST_MALFORMED, '0);
        end else begin
          if (negative) value = -magnitude;
          else value = (magnitude >= MAG_LIMIT) ? POS_MAX : magnitude;
          slot = -1;
          if (letter == CH_UP_T || letter == CH_LO_T) slot = IDX_CLIMATE;
          else if (letter == CH_UP_S || letter == CH_LO_S) slot = IDX_SOIL;
          else if (letter == CH_UP_L || letter == CH_LO_L) slot = IDX_REFRESH;
          if (slot >= 0) begin
            period[slot] = value;
            emit(KIND_STATUS, PERIOD_SET[slot], value);
          end else if (letter == CH_UP_D || letter == CH_LO_D) begin
            if (value <= TOP_DISPLAY_MODE) begin
              disp_mode = value[1:0];
              emit(KIND_STATUS, ST_DISP_SET, value);
              emit(KIND_REFRESH, ST_NONE, '0);
            end else begin
              emit(KIND_STATUS, ST_DISP_BAD, value);
            end
          end else begin
            emit(KIND_STATUS, ST_UNKNOWN, value);
          end
        end
        drop_line();
      end
    end else if (kept < LINE_CAPACITY - 1) begin
      kept++;
      if (!text_done) begin
        if (c == CH_NUL) begin
          text_done = 1'b1;
        end else begin
          case (phase)
            PH_LETTER: begin
              letter = c;
              phase  = PH_COLON;
            end
            PH_COLON: phase = (c == CH_COLON) ? PH_BLANKS : PH_STOPPED;
            PH_BLANKS, PH_SIGNED, PH_DIGITS: begin
              blank = (c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF);
              // skip blanks while still waiting for the sign
              if (!(phase == PH_BLANKS && blank)) begin
                if (phase == PH_BLANKS && (c == CH_PLUS || c == CH_MINUS)) begin
                  negative = (c == CH_MINUS);
                  phase    = PH_SIGNED;
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                  grown      = 64'(magnitude) * 64'd10 + 64'(c - CH_ZERO);
                  magnitude  = (grown > 64'(MAG_LIMIT)) ? MAG_LIMIT : grown[31:0];
                  digit_seen = 1'b1;
                  phase      = PH_DIGITS;
                end else begin
                  phase = PH_STOPPED;
                end
              end
            end
            default: ;
          endcase
        end
      end
    end
    if (fresh.size() != 0) begin
      fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) expected_results.push_back(fresh[i]);
    end
  endtask

  always @(posedge clk) begin
    trig_result_t want;
    if (!rst_n) begin
      period[IDX_CLIMATE] = CLIMATE_PERIOD_RST;
      period[IDX_SOIL]    = SOIL_PERIOD_RST;
      period[IDX_REFRESH] = REFRESH_PERIOD_RST;
      for (int i = 0; i < 3; i++) elapsed[i] = '0;
      disp_mode = '0;
      drop_line();
      expected_results.delete();
    end else begin
      // compare first: a result never belongs to an input taken at the same edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result, kind", '0, 32'(out_kind));
        end else begin
          want = expected_results.pop_front();
          if (out_kind !== want.kind) report("kind", 32'(want.kind), 32'(out_kind));
          if (out_status !== want.status)
            report("status", 32'(want.status), 32'(out_status));
          if (out_applied_value !== want.value)
            report("applied_value", want.value, out_applied_value);
          if (out_display_mode !== want.disp)
            report("display_mode", 32'(want.disp), 32'(out_display_mode));
          if (out_last !== want.last) report("last", 32'(want.last), 32'(out_last));
        end
      end
      if (in_valid && in_ready) predict_results(in_mode, in_rx_byte);
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== tb/sv/serial_command_periodic_trigger_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: drives serial bytes and millisecond ticks, paces the result side, gives the verdict.
module serial_command_periodic_trigger_tb;
  import scpt_pkg::*;

  localparam int LINE_CAP       = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 200;
  localparam int DRAIN_CYCLES   = 100;
  localparam int ITEM_TARGET    = 300;
  localparam int PRESSURE_AT    = 160;
  localparam int MAX_GAP        = 19;

  localparam logic [3:0][7:0] BLANK_CHARS = {CH_FF, CH_VT, CH_TAB, CH_SP};
  localparam logic [7:0][7:0] LETTERS =
    {CH_LO_D, CH_UP_D, CH_LO_L, CH_UP_L, CH_LO_S, CH_UP_S, CH_LO_T, CH_UP_T};

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_results;
  int   items_sent  = 0;
  int   idle_cycles = 0;
  bit   tx_calm     = 1'b0;
  bit   hold_req    = 1'b0;

  scpt_in_if  in_bus ();
  scpt_out_if out_bus ();

  serial_command_periodic_trigger #(.LINE_CAPACITY(LINE_CAP)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  scpt_trigger_checker #(.LINE_CAPACITY(LINE_CAP)) result_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_bus.valid),
    .in_ready          (in_bus.ready),
    .in_mode           (in_bus.mode),
    .in_rx_byte        (in_bus.rx_byte),
    .out_valid         (out_bus.valid),
    .out_ready         (out_bus.ready),
    .out_kind          (out_bus.kind),
    .out_status        (out_bus.status),
    .out_applied_value (out_bus.applied_value),
    .out_display_mode  (out_bus.display_mode),
    .out_last          (out_bus.last),
    .fail_count        (fail_count),
    .pending_results   (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one byte or tick and hold it until the transaction completes.
  task automatic send_item(input logic tick, input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.mode    <= tick;
    in_bus.rx_byte <= b;
    in_bus.valid   <= 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(1'b0, s[i]);
  endtask

  // Result side: random stalls, calm stretches and one long hold-off.
  initial begin
    int stall;
    bit rx_calm;
    bit held;
    rx_calm = 1'b0;
    held    = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_req && !held) begin
        stall = LONG_HOLD;
        held  = 1'b1;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("serial_command_periodic_trigger_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] line[$];
    logic [7:0] letter;
    logic [7:0] c;
    int         pick;
    int         len;
    string      num;
    bit         pressure_done;

    in_bus.valid   = 1'b0;
    in_bus.mode    = 1'b0;
    in_bus.rx_byte = '0;
    out_bus.ready  = 1'b0;
    rst_n          = 1'b0;
    pressure_done  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty line, display command, zero periods, tick order, bad letter and mode
    send_item(1'b0, CH_LF);
    send_text("D:3");
    send_item(1'b0, CH_CR);
    send_text("S:0\n");
    send_item(1'b1, 8'($urandom));
    send_text("T:0\n");
    send_text("L:0\n");
    send_item(1'b1, 8'($urandom));
    send_text("Q:+7\n");
    send_text("d:9\n");

    while (items_sent < ITEM_TARGET) begin
      if (!pressure_done && items_sent >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        send_text("T:0\n");
        send_text("S:0\n");
        send_text("L:0\n");
        // pause until everything has drained, then flood while the sink holds off
        while (pending_results != 0) @(negedge clk);
        hold_req = 1'b1;
        tx_calm  = 1'b1;
        repeat (12) send_item(1'b1, 8'($urandom));
        tx_calm  = 1'b0;
      end
      if ($urandom_range(0, 5) == 0) tx_calm = !tx_calm;
      pick   = $urandom_range(0, 99);
      letter = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(8'h21, 8'h7E))
                                           : LETTERS[$urandom_range(0, 7)];
      line.delete();
      if (pick < 30) begin
        repeat ($urandom_range(1, 6)) send_item(1'b1, 8'($urandom));
      end else begin
        if (pick < 70) begin
          line.push_back(letter);
          line.push_back(CH_COLON);
          repeat ($urandom_range(0, 2)) line.push_back(BLANK_CHARS[$urandom_range(0, 3)]);
          len = $urandom_range(0, 5);
          if (len == 0) line.push_back(CH_MINUS);
          else if (len == 1) line.push_back(CH_PLUS);
          if ($urandom_range(0, 7) == 0) begin
            // long digit strings saturate
            repeat ($urandom_range(1, 14)) line.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          end else begin
            num = $sformatf("%0d", $urandom_range(0, 1) ? $urandom_range(0, 4)
                                                         : $urandom_range(0, 60));
            foreach (num[i]) line.push_back(num[i]);
          end
          if ($urandom_range(0, 3) == 0) line.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end else if (pick < 78) begin
          // past the line capacity: tail bytes are dropped
          line.push_back(letter);
          line.push_back(CH_COLON);
          repeat ($urandom_range(0, 14)) line.push_back(BLANK_CHARS[$urandom_range(0, 3)]);
          len = $urandom_range(LINE_CAP, LINE_CAP + 8);
          while (line.size() < len) line.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (pick < 84) begin
          line.push_back(letter);
          line.push_back(CH_COLON);
          repeat ($urandom_range(1, 4)) line.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          line.insert($urandom_range(0, line.size()), CH_NUL);
        end else if (pick < 92) begin
          repeat ($urandom_range(1, 6)) line.push_back(8'($urandom));
        end else begin
          line.push_back(letter);
          if ($urandom_range(0, 1)) begin
            c = 8'($urandom_range(8'h21, 8'h7E));
            line.push_back((c == CH_COLON) ? CH_PLUS : c);
          end else begin
            line.push_back(CH_COLON);
            if ($urandom_range(0, 1)) line.push_back(BLANK_CHARS[$urandom_range(0, 3)]);
            if ($urandom_range(0, 1)) line.push_back(CH_MINUS);
          end
        end
        line.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        if ($urandom_range(0, 5) == 0) line.push_back(CH_LF);
        foreach (line[i]) send_item(1'b0, line[i]);
      end
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("serial_command_periodic_trigger_tb: PASS");
    end else begin
      $display("serial_command_periodic_trigger_tb: FAIL");
    end
    $finish;
  end

endmodule
